// ===== rtl/isp_pkg.sv =====
// Package for the incremental speed PID: widths, codes, control word, microcode table and a saturation helper.
`default_nettype none
package isp_pkg;

    // Fixed field and datapath widths.
    localparam int DEFAULT_FRACTION_BITS = 8;
    localparam int RPC_FRAC   = 16;
    localparam int ALPHA_FRAC = 16;
    localparam int DUTY_FRAC  = 8;
    localparam int OPA_W  = 28;
    localparam int OPB_W  = 25;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET  = 3'd6;

    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    typedef logic [STEP_W-1:0] step_t;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_SCALE = 3'd1,
        MUL_FILT  = 3'd2,
        MUL_P     = 3'd3,
        MUL_I     = 3'd4,
        MUL_D     = 3'd5
    } mul_sel_t;

    // Datapath operation of one step.
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_RAW      = 4'd1,
        OP_FILT     = 4'd2,
        OP_ERR      = 4'd3,
        OP_SUM_LOAD = 4'd4,
        OP_SUM_ADD  = 4'd5,
        OP_ACC      = 4'd6,
        OP_DRIVE    = 4'd7,
        OP_ZERO     = 4'd8
    } op_t;

    // One control word of the program.
    typedef struct packed {
        mul_sel_t mul_sel;
        op_t      op;
        logic     jmp_zero;
        step_t    jmp_to;
        logic     last;
    } ctrl_t;

    localparam step_t STEP_ZERO = 4'd11;

    // Microcode: scale, filter, error, three products, accumulate, drive, or zeroing on a zero target.
    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t w;
        w = '{mul_sel: MUL_NONE, op: OP_NONE, jmp_zero: 1'b0, jmp_to: '0, last: 1'b0};
        unique case (pc)
            4'd0:  w.mul_sel = MUL_SCALE;
            4'd1:  w.op = OP_RAW;
            4'd2:  w.mul_sel = MUL_FILT;
            4'd3: begin
                w.op = OP_FILT;
                w.jmp_zero = 1'b1;
                w.jmp_to = STEP_ZERO;
            end
            4'd4:  w.op = OP_ERR;
            4'd5:  w.mul_sel = MUL_P;
            4'd6: begin
                w.mul_sel = MUL_I;
                w.op = OP_SUM_LOAD;
            end
            4'd7: begin
                w.mul_sel = MUL_D;
                w.op = OP_SUM_ADD;
            end
            4'd8:  w.op = OP_SUM_ADD;
            4'd9:  w.op = OP_ACC;
            4'd10: begin
                w.op = OP_DRIVE;
                w.last = 1'b1;
            end
            4'd11: begin
                w.op = OP_ZERO;
                w.last = 1'b1;
            end
            default: w.op = OP_NONE;
        endcase
        return w;
    endfunction

    // Saturate a product-wide signed value to 24 bits.
    function automatic logic [23:0] sat24(input logic signed [PROD_W-1:0] v);
        if (v[PROD_W-1:23] != {(PROD_W-23){v[23]}}) begin
            return v[PROD_W-1] ? 24'h800000 : 24'h7FFFFF;
        end
        return v[23:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/incremental_speed_pid.sv =====
// Top level of the incremental speed PID: microcoded sequencer over one shared multiplier.
//
// A control tick (mode 0) runs the step program of the microcode table from its transfer
// to its result, on a shorter path when the target is zero; a set-target item (mode 1)
// is absorbed in the cycle of its transfer and gives no result. In that program one
// registered 28x25 multiplier is shared by the scaling, the filter and the
// three PID products, one product per step. The result sits in an output register; the
// block takes the next item while it waits, and a tick stalls on its last step only if
// the previous result has not been taken yet. The configuration port is always ready;
// write it only while no tick is in progress.
`default_nettype none
module incremental_speed_pid #(
    parameter int FRACTION_BITS = isp_pkg::DEFAULT_FRACTION_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_mode,
    input  wire logic signed [15:0]               s_encoder_delta,
    input  wire logic signed [23:0]               s_new_target,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [15:0]                    m_drive_duty,
    output logic signed [23:0]                    m_speed_estimate,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [isp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [isp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import isp_pkg::*;

    localparam int RAW_SHIFT = RPC_FRAC - FRACTION_BITS;

    // Configuration registers.
    logic [15:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [23:0] rpm_per_count_reg;
    logic [16:0] smooth_factor_reg;
    logic [14:0] duty_limit_reg, start_offset_reg;

    // Loop state.
    logic signed [23:0] target_reg, filt_reg, acc_reg;
    logic signed [25:0] e1_reg, e2_reg;

    // Sequencer and working registers.
    logic               busy_reg;
    step_t              pc_reg;
    logic signed [15:0] delta_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [24:0] diff_reg, err_reg;
    logic               m_valid_reg;
    logic signed [15:0] m_duty_reg;
    logic signed [23:0] m_est_reg;

    ctrl_t ctrl;
    logic  stall;
    logic  s_xfer, cfg_xfer, tgt_clear;
    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic [16:0]              alpha;
    logic [23:0]              raw_sat, filt_calc;
    logic signed [24:0]       diff_calc, err_calc;
    logic signed [PROD_W-1:0] filt_sum;
    logic signed [SUM_W-1:0]  acc_sum, acc_lim;
    logic [23:0]              acc_calc;
    logic signed [25:0]       lim26, off26, drive_sum, drive_clamp, duty_wide;

    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_drive_duty     = m_duty_reg;
    assign m_speed_estimate = m_est_reg;

    assign s_xfer   = s_valid && s_ready;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign ctrl     = ucode(pc_reg);
    assign stall    = busy_reg && ctrl.last && m_valid_reg && !m_ready;
    assign tgt_clear = (s_new_target == 24'sd0)
                    || (target_reg > 24'sd0 && s_new_target < 24'sd0)
                    || (target_reg < 24'sd0 && s_new_target > 24'sd0);

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.mul_sel)
            MUL_SCALE: begin
                mul_a = {{(OPA_W-16){delta_reg[15]}}, delta_reg};
                mul_b = {1'b0, rpm_per_count_reg};
            end
            MUL_FILT: begin
                mul_a = {{(OPA_W-25){diff_reg[24]}}, diff_reg};
                mul_b = {8'b0, alpha};
            end
            MUL_P: begin
                mul_a = {{(OPA_W-25){err_reg[24]}}, err_reg}
                      - {{(OPA_W-26){e1_reg[25]}}, e1_reg};
                mul_b = {9'b0, prop_gain_reg};
            end
            MUL_I: begin
                mul_a = {{(OPA_W-25){err_reg[24]}}, err_reg};
                mul_b = {9'b0, integ_gain_reg};
            end
            MUL_D: begin
                mul_a = {{(OPA_W-25){err_reg[24]}}, err_reg}
                      - {{(OPA_W-27){e1_reg[25]}}, e1_reg, 1'b0}
                      + {{(OPA_W-26){e2_reg[25]}}, e2_reg};
                mul_b = {9'b0, deriv_gain_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Scaling, filter and error arithmetic.
    always_comb begin
        alpha     = (smooth_factor_reg > ALPHA_ONE) ? ALPHA_ONE : smooth_factor_reg;
        raw_sat   = sat24(prod_reg >>> RAW_SHIFT);
        diff_calc = {raw_sat[23], raw_sat} - {filt_reg[23], filt_reg};
        filt_sum  = $signed({{(PROD_W-24){filt_reg[23]}}, filt_reg})
                  + (prod_reg >>> ALPHA_FRAC);
        filt_calc = sat24(filt_sum);
        err_calc  = {target_reg[23], target_reg} - {filt_reg[23], filt_reg};
    end

    // Accumulator update with symmetric clamp.
    always_comb begin
        acc_lim = {{(SUM_W-23){1'b0}}, duty_limit_reg, {DUTY_FRAC{1'b0}}};
        acc_sum = $signed({{(SUM_W-24){acc_reg[23]}}, acc_reg})
                + (sum_reg >>> FRACTION_BITS);
        if (acc_sum > acc_lim) begin
            acc_calc = acc_lim[23:0];
        end else if (acc_sum < -acc_lim) begin
            acc_calc = 24'(-acc_lim);
        end else begin
            acc_calc = acc_sum[23:0];
        end
    end

    // Drive: start duty in the sign of the target, clamp, truncate toward zero.
    always_comb begin
        lim26 = {3'b0, duty_limit_reg, {DUTY_FRAC{1'b0}}};
        off26 = {3'b0, start_offset_reg, {DUTY_FRAC{1'b0}}};
        drive_sum = ((target_reg < 24'sd0) ? -off26 : off26)
                  + {{2{acc_reg[23]}}, acc_reg};
        if (drive_sum > lim26) begin
            drive_clamp = lim26;
        end else if (drive_sum < -lim26) begin
            drive_clamp = -lim26;
        end else begin
            drive_clamp = drive_sum;
        end
        if (drive_clamp < 26'sd0) begin
            duty_wide = (drive_clamp + 26'sd255) >>> DUTY_FRAC;
        end else begin
            duty_wide = drive_clamp >>> DUTY_FRAC;
        end
    end

    // Control, state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            rpm_per_count_reg <= '0;
            smooth_factor_reg <= ALPHA_ONE;
            duty_limit_reg    <= '0;
            start_offset_reg  <= '0;
            target_reg  <= '0;
            filt_reg    <= '0;
            acc_reg     <= '0;
            e1_reg      <= '0;
            e2_reg      <= '0;
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Configuration writes.
            if (cfg_xfer) begin
                unique case (cfg_index)
                    REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[15:0];
                    REG_INTEG_GAIN:    integ_gain_reg    <= cfg_data[15:0];
                    REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[15:0];
                    REG_RPM_PER_COUNT: rpm_per_count_reg <= cfg_data;
                    REG_SMOOTH_FACTOR: smooth_factor_reg <= cfg_data[16:0];
                    REG_DUTY_LIMIT:    duty_limit_reg    <= cfg_data[14:0];
                    REG_START_OFFSET:  start_offset_reg  <= cfg_data[14:0];
                    default: ;
                endcase
            end

            // Result register drains on its transfer, unless the last step refills it now.
            if (m_valid_reg && m_ready && !(busy_reg && ctrl.last)) begin
                m_valid_reg <= 1'b0;
            end

            // Input transfer: start a tick or store a new target.
            if (s_xfer) begin
                if (s_mode) begin
                    if (tgt_clear) begin
                        filt_reg <= '0;
                        acc_reg  <= '0;
                        e1_reg   <= '0;
                        e2_reg   <= '0;
                    end
                    target_reg <= s_new_target;
                end else begin
                    busy_reg <= 1'b1;
                    pc_reg   <= '0;
                end
            end

            // Program step.
            if (busy_reg && !stall) begin
                unique case (ctrl.op)
                    OP_FILT: filt_reg <= filt_calc;
                    OP_ACC: begin
                        acc_reg <= acc_calc;
                        e2_reg  <= e1_reg;
                        e1_reg  <= {err_reg[24], err_reg};
                    end
                    OP_DRIVE: m_valid_reg <= 1'b1;
                    OP_ZERO: begin
                        filt_reg    <= '0;
                        acc_reg     <= '0;
                        e1_reg      <= '0;
                        e2_reg      <= '0;
                        m_valid_reg <= 1'b1;
                    end
                    default: ;
                endcase
                if (ctrl.last) begin
                    busy_reg <= 1'b0;
                    pc_reg   <= '0;
                end else if (ctrl.jmp_zero && target_reg == 24'sd0) begin
                    pc_reg <= ctrl.jmp_to;
                end else begin
                    pc_reg <= pc_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_xfer && !s_mode) begin
            delta_reg <= s_encoder_delta;
        end
        if (busy_reg && !stall) begin
            if (ctrl.mul_sel != MUL_NONE) begin
                prod_reg <= mul_a * mul_b;
            end
            unique case (ctrl.op)
                OP_RAW:      diff_reg <= diff_calc;
                OP_ERR:      err_reg  <= err_calc;
                OP_SUM_LOAD: sum_reg  <= {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                OP_SUM_ADD:  sum_reg  <= sum_reg
                                       + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                OP_DRIVE: begin
                    m_duty_reg <= duty_wide[15:0];
                    m_est_reg  <= filt_reg;
                end
                OP_ZERO: begin
                    m_duty_reg <= '0;
                    m_est_reg  <= filt_reg;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/isp_checker.sv =====
// Port-level checker for the incremental speed PID, with its bind to the top level.
`default_nettype none
module isp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_mode,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_drive_duty,
    input wire logic [23:0] m_speed_estimate,
    input wire logic        cfg_ready
);

    // A tick transfer makes the block busy in the next cycle.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_mode) |=> !s_ready)
        else $error("input still ready after a tick transfer");

    // A set-target transfer never produces a result.
    a_target_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode && !m_valid) |=> !m_valid)
        else $error("result appeared after a set-target transfer");

    // A new result appears exactly when a tick finishes.
    a_result_ends_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (s_ready && $past(!s_ready)))
        else $error("result appeared outside the end of a tick");

    // A waiting result holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_drive_duty) && $stable(m_speed_estimate)))
        else $error("result changed or dropped before its transfer");

    // The configuration port never stalls.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind incremental_speed_pid isp_checker u_isp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_mode           (s_mode),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_drive_duty     (m_drive_duty),
    .m_speed_estimate (m_speed_estimate),
    .cfg_ready        (cfg_ready)
);
`default_nettype wire
